@@ rtl/gda_pkg.sv @@
// ----------------------------------------------------------------------------
// gda_pkg
// Types, microcode program and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned ADD_W   = 16;
	localparam int unsigned OFF_W   = 9;

	localparam logic [ADD_W-1:0]   DAYS_TO_ADD_RST = ADD_W'(7);
	localparam logic [YEAR_W-1:0]  YEAR_MAX        = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0] MONTH_DEC       = MONTH_W'(12);
	localparam logic [OFF_W-1:0]   YEAR_DAYS       = OFF_W'(365);
	localparam logic [OFF_W-1:0]   LEAP_YEAR_DAYS  = OFF_W'(366);
	// 2^19 / 100 rounded up, exact quotient for every 14-bit year
	localparam logic [12:0]        DIV100_RECIP    = 13'd5243;

	typedef logic [2:0] step_t;

	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_CLAMP  = 3'd1,
		OP_OFFSET = 3'd2,
		OP_REMAIN = 3'd3,
		OP_YEAR   = 3'd4,
		OP_CHECK  = 3'd5,
		OP_MONTH  = 3'd6,
		OP_EMIT   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER    = 3'd0,
		COND_NO_IN    = 3'd1,
		COND_FITS     = 3'd2,
		COND_MORE     = 3'd3,
		COND_OVF      = 3'd4,
		COND_NOT_DONE = 3'd5,
		COND_OUT_BUSY = 3'd6
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ucode_t;

	typedef struct packed {
		logic no_in;
		logic fits;
		logic more;
		logic ovf;
		logic not_done;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	localparam step_t ST_IDLE   = 3'd0;
	localparam step_t ST_CLAMP  = 3'd1;
	localparam step_t ST_OFFSET = 3'd2;
	localparam step_t ST_REMAIN = 3'd3;
	localparam step_t ST_YEAR   = 3'd4;
	localparam step_t ST_CHECK  = 3'd5;
	localparam step_t ST_MONTH  = 3'd6;
	localparam step_t ST_EMIT   = 3'd7;

	// control store: jump on condition, else go to nxt
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		case (pc)
			ST_IDLE:   w = '{OP_LOAD,   COND_NO_IN,    ST_IDLE,  ST_CLAMP};
			ST_CLAMP:  w = '{OP_CLAMP,  COND_NEVER,    ST_IDLE,  ST_OFFSET};
			ST_OFFSET: w = '{OP_OFFSET, COND_NEVER,    ST_IDLE,  ST_REMAIN};
			ST_REMAIN: w = '{OP_REMAIN, COND_FITS,     ST_CHECK, ST_YEAR};
			ST_YEAR:   w = '{OP_YEAR,   COND_MORE,     ST_YEAR,  ST_CHECK};
			ST_CHECK:  w = '{OP_CHECK,  COND_OVF,      ST_EMIT,  ST_MONTH};
			ST_MONTH:  w = '{OP_MONTH,  COND_NOT_DONE, ST_MONTH, ST_EMIT};
			ST_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY, ST_EMIT,  ST_IDLE};
			default:   w = '{OP_LOAD,   COND_NEVER,    ST_IDLE,  ST_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		logic [26:0]       prod;
		logic [7:0]        q;
		logic [YEAR_W-1:0] h;
		logic              by100;
		prod  = 27'(y) * 27'(DIV100_RECIP);
		q     = prod[26:19];
		// q * 100 as shifts and adds
		h     = {q, 6'b0} + YEAR_W'({q, 5'b0}) + YEAR_W'({q, 2'b0});
		by100 = (h == y);
		return ((y[1:0] == 2'b00) && !by100) || (by100 && (q[1:0] == 2'b00));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: n = DAY_W'(30);
			4'd2:                    n = leap ? DAY_W'(29) : DAY_W'(28);
			default:                 n = DAY_W'(31);
		endcase
		return n;
	endfunction

	function automatic logic [OFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [OFF_W-1:0] n;
		case (m)
			4'd2:    n = OFF_W'(31);
			4'd3:    n = OFF_W'(59);
			4'd4:    n = OFF_W'(90);
			4'd5:    n = OFF_W'(120);
			4'd6:    n = OFF_W'(151);
			4'd7:    n = OFF_W'(181);
			4'd8:    n = OFF_W'(212);
			4'd9:    n = OFF_W'(243);
			4'd10:   n = OFF_W'(273);
			4'd11:   n = OFF_W'(304);
			4'd12:   n = OFF_W'(334);
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/gda_seq.sv @@
// ----------------------------------------------------------------------------
// gda_seq
// Step counter and control store; picks the next step from the datapath flags.
// ----------------------------------------------------------------------------
module gda_seq import gda_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctl_t   ctl
);

	step_t  pc_q;
	ucode_t uw;
	logic   take;

	assign uw     = ucode_rom(pc_q);
	assign ctl.op = uw.op;

	always_comb begin
		case (uw.cond)
			COND_NEVER:    take = 1'b0;
			COND_NO_IN:    take = flags.no_in;
			COND_FITS:     take = flags.fits;
			COND_MORE:     take = flags.more;
			COND_OVF:      take = flags.ovf;
			COND_NOT_DONE: take = flags.not_done;
			COND_OUT_BUSY: take = flags.out_busy;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= take ? uw.jmp : uw.nxt;
		end
	end

endmodule

@@ rtl/gregorian_date_add_days_core.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// Adds the configured day count to a Gregorian date.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one date item (in_day, in_month,
// in_year); output channel out_valid/out_ready carries the resulting date and
// year_overflow. cfg_wr_en/cfg_wr_data write days_to_add (reset value 7);
// write it only while the block is idle.
// One item is worked at a time by a microcoded sequencer: a fixed program of
// eight steps drives the datapath. After an item is accepted the sequencer
// clamps the day, forms the day-of-year offset, steps whole years (about 180
// at most for a day count of 65535), checks for year overflow, walks the
// months of the final year (at most 11) and writes the result; on year
// overflow the month walk is skipped. The next item can be taken in the cycle
// after the result is written, not before. in_ready is high only in the idle
// step. A finished result sits in the output register while the next item is
// accepted and worked; if the receiver still stalls when that next result is
// ready, the sequencer waits in its emit step.
// Reset returns the sequencer to idle, empties the output register and loads
// days_to_add with 7.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core import gda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [ADD_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DAY_W-1:0]   in_day,
	input  logic [MONTH_W-1:0] in_month,
	input  logic [YEAR_W-1:0]  in_year,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DAY_W-1:0]   out_day,
	output logic [MONTH_W-1:0] out_month,
	output logic [YEAR_W-1:0]  out_year,
	output logic               year_overflow
);

	ctl_t   ctl;
	flags_t flags;

	logic [ADD_W-1:0]   days_to_add_q;
	logic [DAY_W-1:0]   d_q;
	logic [MONTH_W-1:0] m_q;
	logic [YEAR_W-1:0]  y_q;
	logic [ADD_W-1:0]   x_q;
	logic [OFF_W-1:0]   off_q;
	logic               ovf_q;
	logic               out_valid_q;

	logic               leap;
	logic [OFF_W-1:0]   ylen;
	logic [OFF_W-1:0]   rem;
	logic [DAY_W-1:0]   mdays;
	logic               fits;
	logic               more;
	logic               done;
	logic               out_free;

	gda_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign in_ready = (ctl.op == OP_LOAD);
	assign out_free = !out_valid_q || out_ready;

	assign leap  = leap_year(y_q);
	assign ylen  = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
	assign rem   = ylen - off_q;
	assign mdays = month_days(m_q, leap);
	assign fits  = (x_q <= ADD_W'(rem));
	assign more  = (x_q > ADD_W'(ylen));
	assign done  = (m_q == MONTH_DEC) || (off_q <= OFF_W'(mdays));

	assign flags.no_in    = !in_valid;
	assign flags.fits     = fits;
	assign flags.more     = more;
	assign flags.ovf      = (y_q > YEAR_MAX);
	assign flags.not_done = !done;
	assign flags.out_busy = !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_to_add_q <= DAYS_TO_ADD_RST;
		end else if (cfg_wr_en) begin
			days_to_add_q <= cfg_wr_data;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				if (in_valid) begin
					d_q <= (in_day == '0) ? DAY_W'(1) : in_day;
					if (in_month == '0)
						m_q <= MONTH_W'(1);
					else if (in_month > MONTH_DEC)
						m_q <= MONTH_DEC;
					else
						m_q <= in_month;
					if (in_year == '0)
						y_q <= YEAR_W'(1);
					else if (in_year > YEAR_MAX)
						y_q <= YEAR_MAX;
					else
						y_q <= in_year;
					x_q <= days_to_add_q;
				end
			end
			OP_CLAMP: begin
				if (d_q > mdays)
					d_q <= mdays;
			end
			OP_OFFSET: begin
				off_q <= days_before(m_q) + OFF_W'(d_q)
					+ OFF_W'(leap && (m_q > MONTH_W'(2)));
			end
			OP_REMAIN: begin
				if (fits) begin
					off_q <= off_q + x_q[OFF_W-1:0];
				end else begin
					x_q <= x_q - ADD_W'(rem);
					y_q <= y_q + YEAR_W'(1);
				end
			end
			OP_YEAR: begin
				if (more) begin
					x_q <= x_q - ADD_W'(ylen);
					y_q <= y_q + YEAR_W'(1);
				end else begin
					off_q <= x_q[OFF_W-1:0];
				end
			end
			OP_CHECK: begin
				ovf_q <= (y_q > YEAR_MAX);
				m_q   <= MONTH_W'(1);
			end
			OP_MONTH: begin
				if (!done) begin
					off_q <= off_q - OFF_W'(mdays);
					m_q   <= m_q + MONTH_W'(1);
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					out_day       <= ovf_q ? DAY_W'(31) : off_q[DAY_W-1:0];
					out_month     <= ovf_q ? MONTH_DEC : m_q;
					out_year      <= ovf_q ? YEAR_MAX : y_q;
					year_overflow <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/gda_checker.sv @@
// ----------------------------------------------------------------------------
// gda_checker
// Port-level checks on the date adder, bound to the top level.
// ----------------------------------------------------------------------------
module gda_checker import gda_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DAY_W-1:0]   out_day,
	input logic [MONTH_W-1:0] out_month,
	input logic [YEAR_W-1:0]  out_year,
	input logic               year_overflow
);

	// one item at a time: the sequencer leaves idle after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted item");

	a_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && year_overflow |->
			out_year == YEAR_MAX && out_month == MONTH_DEC && out_day == DAY_W'(31))
		else $error("overflow result is not 31 december 9999");

	a_date_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_day != '0 && out_month != '0 && out_month <= MONTH_DEC
			&& out_year != '0 && out_year <= YEAR_MAX)
		else $error("result date out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_day)
			&& $stable(out_month) && $stable(out_year) && $stable(year_overflow))
		else $error("result changed while stalled");

endmodule

bind gregorian_date_add_days_core gda_checker u_gda_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_day       (out_day),
	.out_month     (out_month),
	.out_year      (out_year),
	.year_overflow (year_overflow)
);

@@ tb/gregorian_date_add_days_core_test.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core_test
// Self-checking bench for the date adder. Dates go in through a valid/ready
// item channel. Every accepted date is run through a calendar predictor at
// the current day count. Each result is checked field by field against the
// oldest pending prediction. Directed cases cover field clamping, leap rules,
// year-end landings and overflow. Random phases follow, each with its own day
// count, with bursts of idling on both sides.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core_test;
	import gda_pkg::*;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_in_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               ovf;
	} date_out_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [ADD_W-1:0]   cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic [DAY_W-1:0]   in_day;
	logic [MONTH_W-1:0] in_month;
	logic [YEAR_W-1:0]  in_year;
	logic               out_valid;
	logic               out_ready;
	logic [DAY_W-1:0]   out_day;
	logic [MONTH_W-1:0] out_month;
	logic [YEAR_W-1:0]  out_year;
	logic               year_overflow;

	logic [ADD_W-1:0] days_model;
	date_out_t        pending_dates[$];
	date_in_t         seen_date;
	date_out_t        want_date;
	int               mismatch_count;
	bit               idle_on;
	int               ready_hold;

	gregorian_date_add_days_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_day       (in_day),
		.in_month     (in_month),
		.in_year      (in_year),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_day      (out_day),
		.out_month    (out_month),
		.out_year     (out_year),
		.year_overflow(year_overflow)
	);

	always #5 clk = ~clk;

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned year_days(input int unsigned y);
		return is_leap(y) ? 366 : 365;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		int unsigned n;
		case (m)
			4, 6, 9, 11: n = 30;
			2:           n = is_leap(y) ? 29 : 28;
			default:     n = 31;
		endcase
		return n;
	endfunction

	// calendar result of start date plus add days, with input clamping
	function automatic date_out_t date_after_days(input date_in_t s, input logic [ADD_W-1:0] add);
		int unsigned d, m, y, x, doy, left, y2, off, mo;
		date_out_t   r;
		d = s.day;
		m = s.month;
		y = s.year;
		x = add;
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (y < 1) y = 1;
		if (y > YEAR_MAX) y = YEAR_MAX;
		if (d < 1) d = 1;
		if (d > days_in_month(m, y)) d = days_in_month(m, y);
		doy = d;
		for (mo = 1; mo < m; mo++) doy += days_in_month(mo, y);
		left = year_days(y) - doy;
		if (x <= left) begin
			y2  = y;
			off = doy + x;
		end else begin
			x  -= left;
			y2  = y + 1;
			while (x > year_days(y2)) begin
				x -= year_days(y2);
				y2++;
			end
			off = x;
		end
		if (y2 > YEAR_MAX) begin
			r.day   = DAY_W'(31);
			r.month = MONTH_W'(12);
			r.year  = YEAR_MAX;
			r.ovf   = 1'b1;
		end else begin
			mo = 1;
			while (mo < 12 && off > days_in_month(mo, y2)) begin
				off -= days_in_month(mo, y2);
				mo++;
			end
			r.day   = DAY_W'(off);
			r.month = MONTH_W'(mo);
			r.year  = YEAR_W'(y2);
			r.ovf   = 1'b0;
		end
		return r;
	endfunction

	// predict on every accepted date, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_dates.size() == 0) begin
					$display("%0t: result with no date pending, got %0d/%0d/%0d ovf %0b",
						$time, out_day, out_month, out_year, year_overflow);
					mismatch_count++;
				end else begin
					want_date = pending_dates.pop_front();
					if (out_day !== want_date.day) begin
						$display("%0t: out_day expected %0d got %0d", $time, want_date.day, out_day);
						mismatch_count++;
					end
					if (out_month !== want_date.month) begin
						$display("%0t: out_month expected %0d got %0d",
							$time, want_date.month, out_month);
						mismatch_count++;
					end
					if (out_year !== want_date.year) begin
						$display("%0t: out_year expected %0d got %0d", $time, want_date.year, out_year);
						mismatch_count++;
					end
					if (year_overflow !== want_date.ovf) begin
						$display("%0t: year_overflow expected %0b got %0b",
							$time, want_date.ovf, year_overflow);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				seen_date.day   = in_day;
				seen_date.month = in_month;
				seen_date.year  = in_year;
				pending_dates.push_back(date_after_days(seen_date, days_model));
			end
		end
	end

	// receiver side: random stall bursts
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			ready_hold  = $urandom_range(1, 7) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_date(input int unsigned d, input int unsigned m, input int unsigned y);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_day   <= DAY_W'(d);
		in_month <= MONTH_W'(m);
		in_year  <= YEAR_W'(y);
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and let every pending result drain
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_days_to_add(input int unsigned v);
		wait_idle();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ADD_W'(v);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		days_model   = ADD_W'(v);
	endtask

	task automatic test_reset_count();
		send_date(25, 12, 2023);
		send_date(24, 12, 2023);
		send_date(28, 2, 2024);
	endtask

	task automatic test_clamping();
		set_days_to_add(0);
		send_date(0, 5, 2020);
		send_date(15, 0, 2021);
		send_date(10, 15, 2021);
		send_date(1, 1, 0);
		send_date(31, 15, 16383);
		send_date(31, 4, 2022);
		send_date(29, 2, 2023);
		send_date(30, 2, 2024);
		send_date(29, 2, 1900);
		send_date(29, 2, 2000);
		set_days_to_add(1);
		send_date(31, 12, 1999);
		send_date(28, 2, 2100);
	endtask

	// landings on and just past the last day of a year
	task automatic test_year_end();
		set_days_to_add(365);
		send_date(31, 12, 2000);
		send_date(1, 1, 2001);
		set_days_to_add(366);
		send_date(31, 12, 2003);
	endtask

	task automatic test_overflow();
		set_days_to_add(65535);
		send_date(1, 1, 1);
		send_date(1, 1, 9820);
		send_date(1, 1, 9999);
		set_days_to_add(1);
		send_date(31, 12, 9999);
		send_date(30, 12, 9999);
	endtask

	task automatic test_random();
		int unsigned d, m, y;
		int          p, i;
		for (p = 0; p < 18; p++) begin
			case ($urandom_range(0, 5))
				0:       set_days_to_add(16'hFFFF);
				1:       set_days_to_add(0);
				2:       set_days_to_add($urandom_range(1, 31));
				3:       set_days_to_add($urandom_range(300, 800));
				default: set_days_to_add($urandom_range(0, 16'hFFFF));
			endcase
			// quiet stretches in between, and none at the end
			idle_on = (p < 15) && (p % 4 != 3);
			for (i = 0; i < 50; i++) begin
				if ($urandom_range(0, 9) < 2) begin
					d = $urandom_range(0, 31);
					m = $urandom_range(0, 15);
					y = $urandom_range(0, 16383);
				end else begin
					case ($urandom_range(0, 3))
						0:       y = $urandom_range(9800, 9999);
						1:       y = $urandom_range(1, 400);
						default: y = $urandom_range(1, 9999);
					endcase
					m = $urandom_range(1, 12);
					if ($urandom_range(0, 3) == 0) d = days_in_month(m, y);
					else d = $urandom_range(1, days_in_month(m, y));
				end
				send_date(d, m, y);
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		in_day         = '0;
		in_month       = '0;
		in_year        = '0;
		out_ready      = 1'b0;
		ready_hold     = 0;
		idle_on        = 1'b1;
		mismatch_count = 0;
		days_model     = DAYS_TO_ADD_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_count();
		test_clamping();
		test_year_end();
		test_overflow();
		test_random();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("gregorian_date_add_days_core_test passed");
		end else begin
			$display("gregorian_date_add_days_core_test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout, %0d dates still pending", $time, pending_dates.size());
		$display("gregorian_date_add_days_core_test failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/gda_pkg.sv
rtl/gda_seq.sv
rtl/gregorian_date_add_days_core.sv
rtl/gda_checker.sv
tb/gregorian_date_add_days_core_test.sv
